// ----- sv/gtsb_pkg.sv -----
`timescale 1ns / 1ps

package gtsb_pkg;

    localparam int VTX_W            = 12;
    localparam int CORNER_W         = 2;
    localparam int ID_W             = 12;
    localparam int TOTAL_W          = 13;
    localparam int EPOCH_W          = 4;
    localparam int CORNERS          = 3;
    localparam int VERTEX_SLOTS_DEF = 4096;
    localparam int STRIP_SLOTS_DEF  = 4096;

    localparam logic [CORNER_W-1:0] CORNER_0    = 2'd0;
    localparam logic [CORNER_W-1:0] CORNER_1    = 2'd1;
    localparam logic [CORNER_W-1:0] CORNER_2    = 2'd2;
    localparam logic [CORNER_W-1:0] CORNER_WRAP = 2'd3;

    localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

    typedef struct packed {
        logic             group_start;
        logic [VTX_W-1:0] vertex_a;
        logic [VTX_W-1:0] vertex_b;
        logic [VTX_W-1:0] vertex_c;
    } in_t;

    typedef struct packed {
        logic [CORNER_W-1:0] corner_used;
        logic [ID_W-1:0]     strip_id;
        logic                new_strip;
        logic [TOTAL_W-1:0]  strip_total;
        logic                capacity_overflow;
    } out_t;

    typedef enum logic [3:0] {
        ST_CLR_RST,
        ST_IDLE,
        ST_CLR_GRP,
        ST_LA,
        ST_LB,
        ST_LC,
        ST_M1,
        ST_M2,
        ST_W1,
        ST_W2
    } state_t;

    typedef struct packed {
        logic                busy;
        logic                accept;
        logic                sweep;
        logic                look;
        logic [CORNER_W-1:0] look_k;
        logic                hit_en;
        logic [CORNER_W-1:0] hit_k;
        logic                chk_en;
        logic [CORNER_W-1:0] chk_k;
        logic                decide;
        logic                wr_first;
        logic                wr_second;
    } ctrl_t;

    typedef struct packed {
        logic go_clear;
        logic sweep_last;
        logic ext;
    } stat_t;

    function automatic int addr_width(input int depth);
        addr_width = (depth > 1) ? $clog2(depth) : 1;
    endfunction

    function automatic logic [CORNER_W-1:0] next_corner(input logic [CORNER_W-1:0] c);
        next_corner = (c == CORNER_2) ? CORNER_0 : c + CORNER_1;
    endfunction

endpackage

// ----- sv/gtsb_ram.sv -----
`timescale 1ns / 1ps

module gtsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = gtsb_pkg::addr_width(DEPTH)
) (
    input  logic             clk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/gtsb_seq.sv -----
`timescale 1ns / 1ps

module gtsb_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  gtsb_pkg::stat_t stat,
    output gtsb_pkg::ctrl_t ctrl
);

    gtsb_pkg::state_t state_reg;
    gtsb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gtsb_pkg::ST_CLR_RST;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gtsb_pkg::ST_CLR_RST:
            begin
                if (stat.sweep_last)
                begin
                    state_next = gtsb_pkg::ST_IDLE;
                end
            end
            gtsb_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = stat.go_clear ? gtsb_pkg::ST_CLR_GRP : gtsb_pkg::ST_LA;
                end
            end
            gtsb_pkg::ST_CLR_GRP:
            begin
                if (stat.sweep_last)
                begin
                    state_next = gtsb_pkg::ST_LA;
                end
            end
            gtsb_pkg::ST_LA: state_next = gtsb_pkg::ST_LB;
            gtsb_pkg::ST_LB: state_next = gtsb_pkg::ST_LC;
            gtsb_pkg::ST_LC: state_next = gtsb_pkg::ST_M1;
            gtsb_pkg::ST_M1: state_next = gtsb_pkg::ST_M2;
            gtsb_pkg::ST_M2: state_next = gtsb_pkg::ST_W1;
            gtsb_pkg::ST_W1: state_next = stat.ext ? gtsb_pkg::ST_W2 : gtsb_pkg::ST_IDLE;
            gtsb_pkg::ST_W2: state_next = gtsb_pkg::ST_IDLE;
            default:         state_next = gtsb_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl      = '0;
        ctrl.busy = (state_reg != gtsb_pkg::ST_IDLE);
        unique case (state_reg)
            gtsb_pkg::ST_CLR_RST,
            gtsb_pkg::ST_CLR_GRP:
            begin
                ctrl.sweep = 1'b1;
            end
            gtsb_pkg::ST_IDLE:
            begin
                ctrl.accept = start;
            end
            gtsb_pkg::ST_LA:
            begin
                ctrl.look   = 1'b1;
                ctrl.look_k = gtsb_pkg::CORNER_0;
            end
            gtsb_pkg::ST_LB:
            begin
                ctrl.look   = 1'b1;
                ctrl.look_k = gtsb_pkg::CORNER_1;
                ctrl.hit_en = 1'b1;
                ctrl.hit_k  = gtsb_pkg::CORNER_0;
            end
            gtsb_pkg::ST_LC:
            begin
                ctrl.look   = 1'b1;
                ctrl.look_k = gtsb_pkg::CORNER_2;
                ctrl.hit_en = 1'b1;
                ctrl.hit_k  = gtsb_pkg::CORNER_1;
                ctrl.chk_en = 1'b1;
                ctrl.chk_k  = gtsb_pkg::CORNER_0;
            end
            gtsb_pkg::ST_M1:
            begin
                ctrl.hit_en = 1'b1;
                ctrl.hit_k  = gtsb_pkg::CORNER_2;
                ctrl.chk_en = 1'b1;
                ctrl.chk_k  = gtsb_pkg::CORNER_1;
            end
            gtsb_pkg::ST_M2:
            begin
                ctrl.chk_en = 1'b1;
                ctrl.chk_k  = gtsb_pkg::CORNER_2;
                ctrl.decide = 1'b1;
            end
            gtsb_pkg::ST_W1:
            begin
                ctrl.wr_first = 1'b1;
            end
            gtsb_pkg::ST_W2:
            begin
                ctrl.wr_second = 1'b1;
            end
            default:
            begin
                ctrl.busy = 1'b1;
            end
        endcase
    end

endmodule

// ----- sv/greedy_triangle_strip_builder_top.sv -----
`timescale 1ns / 1ps

// Greedy triangle strip builder. A triangle is accepted at a rising edge with start
// high and busy low; item carries the group start flag and the three vertex indices.
// One result beat per triangle appears on result for exactly one cycle, marked by
// result_valid; the receiver cannot hold it off and takes it at the edge ending that cycle.
// The start corner register is written through cfg_valid, cfg_ready and cfg_data. The user
// writes it only while idle; the block does not enforce this. cfg_ready is always high.
// A triangle goes through three vertex table reads and three strip table reads on
// single-ported memories, then a write in W1 (new strip) or in W1 and W2 (extension, where
// the old strip end must be cleared before the new end is written). The result is
// registered from W1 or, for an extension, W2, and shows in the same cycle as busy falls,
// so a new triangle is taken only once the previous one's result shows.
// Vertex table entries carry a group epoch; a group start advances the epoch and restarts
// the strip count. When the epoch wraps, and after reset, a clearing pass over the whole
// vertex table runs with busy high; every fifteenth group start pays this pass.
// Configuration writes are still taken during the pass.

module greedy_triangle_strip_builder_top #(
    parameter int VERTEX_SLOTS = gtsb_pkg::VERTEX_SLOTS_DEF,
    parameter int STRIP_SLOTS  = gtsb_pkg::STRIP_SLOTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  gtsb_pkg::in_t                 item,
    output logic                          result_valid,
    output gtsb_pkg::out_t                result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gtsb_pkg::CORNER_W-1:0] cfg_data
);

    localparam int VAW   = gtsb_pkg::addr_width(VERTEX_SLOTS);
    localparam int SIW   = gtsb_pkg::addr_width(STRIP_SLOTS);
    localparam int CW    = $clog2(STRIP_SLOTS + 1);
    localparam int VM_W  = gtsb_pkg::EPOCH_W + SIW;
    localparam int CMP_W = ((VAW > gtsb_pkg::VTX_W) ? VAW : gtsb_pkg::VTX_W) + 1;
    localparam int SX_W  = (SIW > gtsb_pkg::ID_W) ? SIW : gtsb_pkg::ID_W;
    localparam int TX_W  = (CW > gtsb_pkg::TOTAL_W) ? CW : gtsb_pkg::TOTAL_W;

    gtsb_pkg::ctrl_t ctrl;
    gtsb_pkg::stat_t stat;

    gtsb_pkg::in_t                  item_reg;
    gtsb_pkg::out_t                 result_reg;
    logic                           result_valid_reg;
    logic [gtsb_pkg::CORNER_W-1:0]  start_corner_reg;
    logic [gtsb_pkg::EPOCH_W-1:0]   epoch_reg;
    logic [CW-1:0]                  counter_reg;
    logic [VAW-1:0]                 sweep_ptr_reg;
    logic                           hit_reg   [gtsb_pkg::CORNERS];
    logic [SIW-1:0]                 sidx_reg  [gtsb_pkg::CORNERS];
    logic                           match_reg [gtsb_pkg::CORNERS];
    logic [gtsb_pkg::CORNER_W-1:0]  corner_reg;
    logic                           ext_reg;
    logic                           full_reg;
    logic [SIW-1:0]                 strip_reg;

    logic [gtsb_pkg::VTX_W-1:0]     vtx      [gtsb_pkg::CORNERS];
    logic [CMP_W-1:0]               vcmp     [gtsb_pkg::CORNERS];
    logic                           in_range [gtsb_pkg::CORNERS];
    logic [VAW-1:0]                 vaddr    [gtsb_pkg::CORNERS];

    logic                           vm_en;
    logic                           vm_we;
    logic [VAW-1:0]                 vm_addr;
    logic [VM_W-1:0]                vm_wdata;
    logic [VM_W-1:0]                vm_rdata;
    logic [gtsb_pkg::EPOCH_W-1:0]   rd_epoch;
    logic [SIW-1:0]                 rd_strip;

    logic                           sm_en;
    logic                           sm_we;
    logic [SIW-1:0]                 sm_addr;
    logic [gtsb_pkg::VTX_W-1:0]     sm_wdata;
    logic [gtsb_pkg::VTX_W-1:0]     sm_rdata;

    logic [gtsb_pkg::CORNER_W-1:0]  c1;
    logic [gtsb_pkg::CORNER_W-1:0]  c2;
    logic [gtsb_pkg::CORNER_W-1:0]  start_corner;
    logic                           match_now;
    logic                           ext_next;
    logic [gtsb_pkg::CORNER_W-1:0]  corner_next;
    logic [SIW-1:0]                 strip_next;
    logic                           result_fire;
    logic                           made_strip;
    logic [CW-1:0]                  total_cnt;
    logic [SX_W-1:0]                strip_ext;
    logic [TX_W-1:0]                total_ext;

    gtsb_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    gtsb_ram #(
        .WIDTH (VM_W),
        .DEPTH (VERTEX_SLOTS)
    ) u_vertex_map (
        .clk   (clk),
        .en    (vm_en),
        .we    (vm_we),
        .addr  (vm_addr),
        .wdata (vm_wdata),
        .rdata (vm_rdata)
    );

    gtsb_ram #(
        .WIDTH (gtsb_pkg::VTX_W),
        .DEPTH (STRIP_SLOTS)
    ) u_strip_prev (
        .clk   (clk),
        .en    (sm_en),
        .we    (sm_we),
        .addr  (sm_addr),
        .wdata (sm_wdata),
        .rdata (sm_rdata)
    );

    assign vtx[0] = item_reg.vertex_a;
    assign vtx[1] = item_reg.vertex_b;
    assign vtx[2] = item_reg.vertex_c;

    always_comb
    begin
        for (int k = 0; k < gtsb_pkg::CORNERS; k++)
        begin
            vcmp[k]     = CMP_W'(vtx[k]);
            in_range[k] = (vcmp[k] < CMP_W'(VERTEX_SLOTS));
            vaddr[k]    = vcmp[k][VAW-1:0];
        end
    end

    assign stat.go_clear   = item.group_start && (epoch_reg == gtsb_pkg::EPOCH_LAST);
    assign stat.sweep_last = (sweep_ptr_reg == VAW'(VERTEX_SLOTS - 1));
    assign stat.ext        = ext_reg;

    assign rd_epoch = vm_rdata[VM_W-1 -: gtsb_pkg::EPOCH_W];
    assign rd_strip = vm_rdata[SIW-1:0];

    assign c1           = gtsb_pkg::next_corner(corner_reg);
    assign c2           = gtsb_pkg::next_corner(c1);
    assign start_corner = (start_corner_reg == gtsb_pkg::CORNER_WRAP) ?
                          gtsb_pkg::CORNER_0 : start_corner_reg;

    always_comb
    begin
        vm_we = ctrl.sweep
              | (ctrl.wr_first && (ext_reg || (!full_reg && in_range[c2])))
              | (ctrl.wr_second && in_range[c2]);
        vm_en = ctrl.look | vm_we;
        priority if (ctrl.sweep)
        begin
            vm_addr = sweep_ptr_reg;
        end
        else if (ctrl.look)
        begin
            vm_addr = vaddr[ctrl.look_k];
        end
        else if (ctrl.wr_first && ext_reg)
        begin
            vm_addr = vaddr[corner_reg];
        end
        else
        begin
            vm_addr = vaddr[c2];
        end
        if (ctrl.sweep || (ctrl.wr_first && ext_reg))
        begin
            vm_wdata = {gtsb_pkg::EPOCH_NONE, {SIW{1'b0}}};
        end
        else
        begin
            vm_wdata = {epoch_reg, strip_reg};
        end
    end

    assign sm_we    = ctrl.wr_first && (ext_reg || !full_reg);
    assign sm_en    = ctrl.hit_en | sm_we;
    assign sm_addr  = sm_we ? strip_reg : rd_strip;
    assign sm_wdata = ext_reg ? vtx[corner_reg] : vtx[c1];

    assign match_now = hit_reg[ctrl.chk_k]
                    && (sm_rdata == vtx[gtsb_pkg::next_corner(ctrl.chk_k)]);

    always_comb
    begin
        ext_next    = 1'b1;
        corner_next = gtsb_pkg::CORNER_0;
        priority if (match_reg[0])
        begin
            corner_next = gtsb_pkg::CORNER_0;
        end
        else if (match_reg[1])
        begin
            corner_next = gtsb_pkg::CORNER_1;
        end
        else if (match_now)
        begin
            corner_next = gtsb_pkg::CORNER_2;
        end
        else
        begin
            ext_next    = 1'b0;
            corner_next = start_corner;
        end
        strip_next = ext_next ? sidx_reg[corner_next] : counter_reg[SIW-1:0];
    end

    assign result_fire = (ctrl.wr_first && !ext_reg) || ctrl.wr_second;
    assign made_strip  = !ext_reg && !full_reg;
    assign total_cnt   = made_strip ? CW'(counter_reg + 1'b1) : counter_reg;
    assign strip_ext   = SX_W'(strip_reg);
    assign total_ext   = TX_W'(total_cnt);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_corner_reg <= gtsb_pkg::CORNER_0;
            epoch_reg        <= gtsb_pkg::EPOCH_FIRST;
            counter_reg      <= '0;
            sweep_ptr_reg    <= '0;
            result_valid_reg <= 1'b0;
            ext_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                start_corner_reg <= cfg_data;
            end
            if (ctrl.sweep)
            begin
                sweep_ptr_reg <= stat.sweep_last ? '0 : sweep_ptr_reg + 1'b1;
            end
            if (ctrl.accept && item.group_start)
            begin
                epoch_reg   <= stat.go_clear ? gtsb_pkg::EPOCH_FIRST : epoch_reg + 1'b1;
                counter_reg <= '0;
            end
            else if (ctrl.wr_first && made_strip)
            begin
                counter_reg <= CW'(counter_reg + 1'b1);
            end
            if (ctrl.decide)
            begin
                ext_reg <= ext_next;
            end
            result_valid_reg <= result_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            item_reg <= item;
        end
        if (ctrl.hit_en)
        begin
            hit_reg[ctrl.hit_k]  <= in_range[ctrl.hit_k] && (rd_epoch == epoch_reg);
            sidx_reg[ctrl.hit_k] <= rd_strip;
        end
        if (ctrl.chk_en)
        begin
            match_reg[ctrl.chk_k] <= match_now;
        end
        if (ctrl.decide)
        begin
            corner_reg <= corner_next;
            strip_reg  <= strip_next;
            full_reg   <= (counter_reg == CW'(STRIP_SLOTS));
        end
        if (result_fire)
        begin
            result_reg.corner_used       <= corner_reg;
            result_reg.new_strip         <= !ext_reg;
            result_reg.capacity_overflow <= !ext_reg && full_reg;
            result_reg.strip_id          <= (!ext_reg && full_reg) ?
                                            '0 : strip_ext[gtsb_pkg::ID_W-1:0];
            result_reg.strip_total       <= total_ext[gtsb_pkg::TOTAL_W-1:0];
        end
    end

    assign busy         = ctrl.busy;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- sv/gtsb_checker.sv -----
`timescale 1ns / 1ps

module gtsb_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input gtsb_pkg::in_t                 item,
    input logic                          result_valid,
    input gtsb_pkg::out_t                result,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [gtsb_pkg::CORNER_W-1:0] cfg_data
);

    // An accepted triangle keeps the block busy until its result beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
    else $error("block not busy after accepting a triangle");

    // Results are one beat per triangle and never arrive in adjacent cycles.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
    else $error("result beats in consecutive cycles");

    // A result ends the work on its triangle, so it appears only while idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy && $past(busy))
    else $error("result beat outside the end of an item");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.capacity_overflow) |->
            (result.new_strip && (result.strip_id == '0)))
    else $error("overflow result without new strip or with a strip id");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.corner_used != gtsb_pkg::CORNER_WRAP))
    else $error("result corner out of range");

endmodule

bind greedy_triangle_strip_builder_top gtsb_checker u_gtsb_checker (.*);
